// ===== sv/smpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types, codes and helpers of the sorted minimum priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int VALUE_W       = 32;
    localparam int OCC_W         = 7;
    localparam int STATUS_W      = 2;
    localparam int OUT_TDATA_W   = 40;

    localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed
    {
        logic                      ins;
        logic                      del;
        logic signed [VALUE_W-1:0] value;
    } cell_cmd_t;

    function automatic logic less_signed(input logic signed [VALUE_W-1:0] a,
                                         input logic signed [VALUE_W-1:0] b);
        return a < b;
    endfunction

endpackage
`default_nettype wire

// ===== sv/smpq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted row: keeps its entry, takes the new value or its
// lower neighbor's entry on insert, and its upper neighbor's entry on delete.
// ----------------------------------------------------------------------------
module smpq_cell
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire smpq_pkg::cell_cmd_t               cmd,
    input  wire logic                              prev_valid,
    input  wire logic signed [smpq_pkg::VALUE_W-1:0] prev_value,
    input  wire logic                              next_valid,
    input  wire logic signed [smpq_pkg::VALUE_W-1:0] next_value,
    output logic                                   valid,
    output logic signed [smpq_pkg::VALUE_W-1:0]    value
);

    logic                              valid_reg;
    logic                              valid_next;
    logic signed [smpq_pkg::VALUE_W-1:0] value_reg;
    logic signed [smpq_pkg::VALUE_W-1:0] value_next;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (cmd.ins)
        begin
            valid_next = valid_reg | prev_valid;
            if (prev_valid && smpq_pkg::less_signed(cmd.value, prev_value))
            begin
                value_next = prev_value;
            end
            else if (!valid_reg || smpq_pkg::less_signed(cmd.value, value_reg))
            begin
                value_next = cmd.value;
            end
        end
        else if (cmd.del)
        begin
            valid_next = next_valid;
            value_next = next_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;

endmodule
`default_nettype wire

// ===== sv/sorted_min_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_min_priority_queue
// Bounded ascending priority queue of signed 32-bit values kept in a row of
// sorted cells; inserts and deletes of the smallest entry, one result each.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata                               tuser
// s_axis   in   [31:0] value                        [0] operation
// m_axis   out  [31:0] popped_value, [38:32] occ    [1:0] status
//
// All cells compare and shift in parallel, and the row is updated at the edge
// that accepts the beat, so a beat can follow each cycle while the output is
// taken. The result register holds one beat; input is taken while it is empty
// or being drained. Reset empties the queue at once and needs no clearing pass.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue
#(
    parameter int DEPTH = smpq_pkg::DEPTH_DEFAULT
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [smpq_pkg::VALUE_W-1:0]        s_axis_tdata,  // [31:0] value
    input  wire logic                                s_axis_tuser,  // [0] operation
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [31:0] popped_value, [38:32] occupancy, [39] zero
    output logic [smpq_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    output logic [smpq_pkg::STATUS_W-1:0]            m_axis_tuser   // [1:0] status
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                                s_fire;
    logic                                op_del;
    logic                                full;
    logic                                empty;
    smpq_pkg::cell_cmd_t                 cmd;
    logic [DEPTH-1:0]                    cell_valid;
    logic signed [smpq_pkg::VALUE_W-1:0] cell_value [DEPTH];

    logic                                m_valid_reg;
    logic                                m_valid_next;
    logic [smpq_pkg::VALUE_W-1:0]        popped_reg;
    logic [smpq_pkg::VALUE_W-1:0]        popped_next;
    smpq_pkg::status_t                   status_reg;
    smpq_pkg::status_t                   status_next;
    logic [CW-1:0]                       count_reg;
    logic [CW-1:0]                       count_next;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign op_del        = (s_axis_tuser == smpq_pkg::OP_DELETE);
    assign full          = cell_valid[DEPTH-1];
    assign empty         = !cell_valid[0];

    assign cmd.ins   = s_fire && !op_del && !full;
    assign cmd.del   = s_fire && op_del && !empty;
    assign cmd.value = s_axis_tdata;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic                                pv;
            logic signed [smpq_pkg::VALUE_W-1:0] pval;
            logic                                nv;
            logic signed [smpq_pkg::VALUE_W-1:0] nval;

            if (gi == 0)
            begin : g_first
                assign pv   = 1'b1;
                assign pval = smpq_pkg::VALUE_MIN;
            end
            else
            begin : g_mid
                assign pv   = cell_valid[gi-1];
                assign pval = cell_value[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign nv   = 1'b0;
                assign nval = '0;
            end
            else
            begin : g_inner
                assign nv   = cell_valid[gi+1];
                assign nval = cell_value[gi+1];
            end

            smpq_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .prev_valid (pv),
                .prev_value (pval),
                .next_valid (nv),
                .next_value (nval),
                .valid      (cell_valid[gi]),
                .value      (cell_value[gi])
            );
        end
    endgenerate

    always_comb
    begin
        m_valid_next = m_valid_reg;
        popped_next  = popped_reg;
        status_next  = status_reg;
        count_next   = count_reg;
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (s_fire)
        begin
            m_valid_next = 1'b1;
            popped_next  = '0;
            status_next  = smpq_pkg::ST_DONE;
            if (op_del)
            begin
                if (empty)
                begin
                    status_next = smpq_pkg::ST_EMPTY;
                end
                else
                begin
                    popped_next = cell_value[0];
                    count_next  = count_reg - CW'(1);
                end
            end
            else
            begin
                if (full)
                begin
                    status_next = smpq_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        popped_reg <= popped_next;
        status_reg <= status_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, smpq_pkg::OCC_W'(count_reg), popped_reg};
    assign m_axis_tuser  = status_reg;

`ifndef ASSERT_OFF
    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(count_reg))
        else $error("occupancy count differs from the number of filled cells");

    a_cells_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[1] |-> cell_valid[0])
        else $error("second cell filled while the front cell is empty");

    a_front_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[1] |-> !smpq_pkg::less_signed(cell_value[1], cell_value[0]))
        else $error("front cell is not the smallest entry");

    a_empty_delete: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && op_del && empty |=> m_valid_reg && status_reg == smpq_pkg::ST_EMPTY)
        else $error("delete from an empty queue not reported as empty");
`endif

endmodule
`default_nettype wire
